/* hdl/gifl_pkg.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// gifl_pkg
// Shared types, constants and helpers for the GIF LZW decoder.
// ---------------------------------------------------------------------------
package gifl_pkg;

  localparam int DICT_BITS           = 12;
  localparam int DICT_SIZE           = 1 << DICT_BITS;
  localparam int CODE_W              = 13;
  localparam logic [CODE_W-1:0] NO_CODE = '1;
  localparam int MAX_CODE_BITS_DEF   = 12;
  localparam int STACK_DEPTH_DEF     = 4096;
  localparam logic [3:0] MIN_SIZE_RESET = 4'd8;

  typedef enum logic [1:0] {
    CMD_PUSH    = 2'd0,
    CMD_PULL    = 2'd1,
    CMD_RESTART = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_PIXEL   = 3'd0,
    ST_ACCEPT  = 3'd1,
    ST_REFUSED = 3'd2,
    ST_NEED    = 3'd3,
    ST_ERROR   = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_BIT,
    S_DEC,
    S_ADD,
    S_PREP,
    S_WALK,
    S_POP_RD,
    S_EMIT
  } seq_state_t;

  typedef struct packed {
    logic                 en;
    logic [DICT_BITS-1:0] addr;
    logic [CODE_W-1:0]    prefix;
    logic [7:0]           suffix;
    logic [7:0]           first;
  } dict_wr_t;

  // clamp minimum code size into 2..8
  function automatic logic [3:0] eff_size(input logic [3:0] v);
    logic [3:0] r;
    r = v;
    if (v < 4'd2) r = 4'd2;
    else if (v > 4'd8) r = 4'd8;
    return r;
  endfunction

endpackage
`default_nettype wire

/* hdl/gif_lzw_decoder.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// gif_lzw_decoder
// GIF LZW decoder, variable code width up to MAX_CODE_BITS, one pixel a pull.
// ---------------------------------------------------------------------------
// Channel   Dir  Transaction
// in_*      in   command (tuser[1:0]), data_byte (tdata[7:0])
// out_*     out  status (tuser[2:0]), stop_seen (tuser[3]), pixel (tdata[7:0])
// cfg_*     in   min_code_size (tdata[3:0]); restarts the decoder
//
// Push, restart and refused commands go from idle straight to the result.
// Pull from a filled stack: stack read, then result.
// Pull that decodes: one code bit per cycle through the unpacker, then code
// handling (decode, an optional dictionary add, prep), then one pixel of the
// string per cycle on the dictionary read port; each later pull pops the stack.
// Reset is synchronous; no clearing pass, roots come from the address.
// A waiting result is held in the output register; the sequencer stalls
// only when a second result is ready before the first is taken.
// ---------------------------------------------------------------------------
module gif_lzw_decoder
  import gifl_pkg::*;
#(
  parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF,
  parameter int STACK_DEPTH   = STACK_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] data_byte
  input  wire logic [1:0] in_tuser,   // [1:0] command
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // [7:0] pixel
  output logic [3:0]      out_tuser,  // [2:0] status, [3] stop_seen
  input  wire logic       cfg_tvalid,
  output logic            cfg_tready,
  input  wire logic [7:0] cfg_tdata   // [3:0] min_code_size
);

  logic       idle, cfg_we, cmd_valid;
  logic       res_valid, res_ready, stop_flag;
  status_t    res_status;
  logic [7:0] res_pixel;

  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_pixel_r, out_pixel_nxt;
  logic [3:0] out_user_r, out_user_nxt;

  // configuration only in idle; it wins over a command in the same cycle
  assign cfg_tready = idle;
  assign in_tready  = idle && !cfg_tvalid;
  assign cfg_we     = cfg_tvalid && cfg_tready;
  assign cmd_valid  = in_tvalid && in_tready;
  assign res_ready  = !out_valid_r || out_tready;

  gifl_seq #(
    .MAX_CODE_BITS (MAX_CODE_BITS),
    .STACK_DEPTH   (STACK_DEPTH)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_size   (cfg_tdata[3:0]),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd_t'(in_tuser)),
    .data_byte  (in_tdata),
    .idle       (idle),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res_status (res_status),
    .res_pixel  (res_pixel),
    .stop_flag  (stop_flag)
  );

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_pixel_nxt = out_pixel_r;
    out_user_nxt  = out_user_r;
    if (out_tready) out_valid_nxt = 1'b0;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_pixel_nxt = res_pixel;
      out_user_nxt  = {stop_flag, res_status};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= out_valid_nxt;
    out_pixel_r <= out_pixel_nxt;
    out_user_r  <= out_user_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_pixel_r;
  assign out_tuser  = out_user_r;

endmodule
`default_nettype wire

/* hdl/gifl_dict.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// gifl_dict
// String table: prefix/suffix memory for the chain walk, first-byte memory
// with two read ports. Roots are produced from the address, not stored.
// ---------------------------------------------------------------------------
module gifl_dict
  import gifl_pkg::*;
(
  input  wire logic              clk,
  input  wire logic [CODE_W-1:0] clear_code,
  input  wire dict_wr_t          wr,
  input  wire logic [CODE_W-1:0] walk_addr,
  input  wire logic [CODE_W-1:0] code_addr,
  input  wire logic [CODE_W-1:0] prev_addr,
  output logic [CODE_W-1:0]      walk_prefix,
  output logic [7:0]             walk_suffix,
  output logic [7:0]             code_first,
  output logic [7:0]             prev_first
);

  logic [CODE_W+7:0] ps_mem [DICT_SIZE];
  logic [7:0]        fst_mem [DICT_SIZE];

  logic [CODE_W+7:0] ps_q_r;
  logic [7:0]        cf_q_r, pf_q_r;
  logic [CODE_W-1:0] walk_a_r, code_a_r, prev_a_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      ps_mem[wr.addr]  <= {wr.prefix, wr.suffix};
      fst_mem[wr.addr] <= wr.first;
    end
    ps_q_r   <= ps_mem[walk_addr[DICT_BITS-1:0]];
    cf_q_r   <= fst_mem[code_addr[DICT_BITS-1:0]];
    pf_q_r   <= fst_mem[prev_addr[DICT_BITS-1:0]];
    walk_a_r <= walk_addr;
    code_a_r <= code_addr;
    prev_a_r <= prev_addr;
  end

  // entries below the clear code are roots
  always_comb begin
    if (walk_a_r < clear_code) begin
      walk_prefix = NO_CODE;
      walk_suffix = walk_a_r[7:0];
    end else begin
      walk_prefix = ps_q_r[CODE_W+7:8];
      walk_suffix = ps_q_r[7:0];
    end
    code_first = (code_a_r < clear_code) ? code_a_r[7:0] : cf_q_r;
    prev_first = (prev_a_r < clear_code) ? prev_a_r[7:0] : pf_q_r;
  end

endmodule
`default_nettype wire

/* hdl/gifl_stack.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// gifl_stack
// Output pixel stack, one write and one registered read port.
// ---------------------------------------------------------------------------
module gifl_stack
  import gifl_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF,
  localparam int AW = $clog2(STACK_DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [7:0]    wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic [7:0]         rd_data
);

  logic [7:0] mem [STACK_DEPTH];
  logic [7:0] rd_q_r;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_q_r <= mem[rd_addr];
  end

  assign rd_data = rd_q_r;

endmodule
`default_nettype wire

/* hdl/gifl_seq.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// gifl_seq
// Decode sequencer: bit unpacker, code handling, chain walk and stack pop.
// ---------------------------------------------------------------------------
module gifl_seq
  import gifl_pkg::*;
#(
  parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF,
  parameter int STACK_DEPTH   = STACK_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [3:0] cfg_size,
  input  wire logic       cmd_valid,
  input  wire cmd_t       cmd,
  input  wire logic [7:0] data_byte,
  output logic            idle,
  output logic            res_valid,
  input  wire logic       res_ready,
  output status_t         res_status,
  output logic [7:0]      res_pixel,
  output logic            stop_flag
);

  localparam int AW  = $clog2(STACK_DEPTH);
  localparam int SCW = $clog2(STACK_DEPTH + 1);

  seq_state_t        state_r, state_nxt;
  logic [3:0]        eff_r, eff_nxt;
  logic [SCW-1:0]    cnt_r, cnt_nxt;
  logic [CODE_W-1:0] next_free_r, next_free_nxt;
  logic [3:0]        width_r, width_nxt;
  logic [CODE_W-1:0] prev_r, prev_nxt;
  logic [11:0]       accum_r, accum_nxt;
  logic [3:0]        acc_bits_r, acc_bits_nxt;
  logic [7:0]        held_r, held_nxt;
  logic [3:0]        held_left_r, held_left_nxt;
  logic              failed_r, failed_nxt;
  logic              stop_r, stop_nxt;
  logic [CODE_W-1:0] code_r, code_nxt;
  logic [CODE_W-1:0] walk_r, walk_nxt;
  status_t           status_r, status_nxt;

  logic [CODE_W-1:0] clear_c, stop_c, rst_clear;
  logic [3:0]        rst_eff;
  logic [11:0]       accum_new;
  logic              code_done, prev_none, is_clear, is_stop, bad_code, do_add, dict_ok;
  logic [CODE_W-1:0] nf_inc;
  logic [CODE_W-1:0] walk_prefix;
  logic [7:0]        walk_suffix, code_first, prev_first, stack_q;
  logic [SCW-1:0]    cnt_inc, cnt_dec;
  dict_wr_t          dwr;
  logic              stk_we, stk_re;

  assign clear_c   = CODE_W'(1) << eff_r;
  assign stop_c    = clear_c + CODE_W'(1);
  assign rst_eff   = cfg_we ? eff_size(cfg_size) : eff_r;
  assign rst_clear = CODE_W'(1) << rst_eff;
  assign accum_new = accum_r | (12'(held_r[0]) << acc_bits_r);
  assign code_done = (acc_bits_r + 4'd1) >= width_r;
  assign prev_none = (prev_r == NO_CODE);
  assign is_clear  = (code_r == clear_c);
  assign is_stop   = (code_r == stop_c);
  assign dict_ok   = (next_free_r < CODE_W'(DICT_SIZE));
  assign bad_code  = prev_none ? (code_r >= clear_c) : (dict_ok && code_r > next_free_r);
  assign do_add    = !prev_none && dict_ok;
  assign nf_inc    = next_free_r + CODE_W'(1);
  assign cnt_inc   = cnt_r + SCW'(1);
  assign cnt_dec   = cnt_r - SCW'(1);

  gifl_dict u_dict (
    .clk         (clk),
    .clear_code  (clear_c),
    .wr          (dwr),
    .walk_addr   (walk_nxt),
    .code_addr   (code_r),
    .prev_addr   (prev_r),
    .walk_prefix (walk_prefix),
    .walk_suffix (walk_suffix),
    .code_first  (code_first),
    .prev_first  (prev_first)
  );

  gifl_stack #(.STACK_DEPTH(STACK_DEPTH)) u_stack (
    .clk     (clk),
    .wr_en   (stk_we),
    .wr_addr (cnt_r[AW-1:0]),
    .wr_data (walk_suffix),
    .rd_en   (stk_re),
    .rd_addr (cnt_dec[AW-1:0]),
    .rd_data (stack_q)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (!cfg_we && cmd_valid) begin
          if (cmd == CMD_PULL && !failed_r) begin
            if (cnt_r != '0) state_nxt = S_POP_RD;
            else if (held_left_r != 4'd0) state_nxt = S_BIT;
            else state_nxt = S_EMIT;
          end else begin
            state_nxt = S_EMIT;
          end
        end
      end
      S_BIT: begin
        if (code_done) state_nxt = S_DEC;
        else if (held_left_r == 4'd1) state_nxt = S_EMIT;
      end
      S_DEC: begin
        if (is_clear || is_stop) state_nxt = (held_left_r != 4'd0) ? S_BIT : S_EMIT;
        else if (bad_code) state_nxt = S_EMIT;
        else if (do_add) state_nxt = S_ADD;
        else state_nxt = S_PREP;
      end
      S_ADD:    state_nxt = S_PREP;
      S_PREP:   state_nxt = S_WALK;
      S_WALK: begin
        if (walk_prefix == NO_CODE || cnt_inc == SCW'(STACK_DEPTH)) state_nxt = S_POP_RD;
      end
      S_POP_RD: state_nxt = S_EMIT;
      S_EMIT:   if (res_ready) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // datapath and strobes
  always_comb begin
    eff_nxt       = eff_r;
    cnt_nxt       = cnt_r;
    next_free_nxt = next_free_r;
    width_nxt     = width_r;
    prev_nxt      = prev_r;
    accum_nxt     = accum_r;
    acc_bits_nxt  = acc_bits_r;
    held_nxt      = held_r;
    held_left_nxt = held_left_r;
    failed_nxt    = failed_r;
    stop_nxt      = stop_r;
    code_nxt      = code_r;
    walk_nxt      = walk_r;
    status_nxt    = status_r;
    dwr           = '0;
    stk_we        = 1'b0;
    stk_re        = 1'b0;

    if (cfg_we || (state_r == S_IDLE && cmd_valid && cmd == CMD_RESTART)) begin
      eff_nxt       = rst_eff;
      cnt_nxt       = '0;
      next_free_nxt = rst_clear + CODE_W'(2);
      width_nxt     = rst_eff + 4'd1;
      prev_nxt      = NO_CODE;
      accum_nxt     = '0;
      acc_bits_nxt  = '0;
      held_nxt      = '0;
      held_left_nxt = '0;
      failed_nxt    = 1'b0;
      stop_nxt      = 1'b0;
      status_nxt    = ST_ACCEPT;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (cmd_valid) begin
            if (cmd == CMD_NONE) status_nxt = ST_REFUSED;
            else if (failed_r) status_nxt = ST_ERROR;
            else if (cmd == CMD_PUSH) begin
              if (held_left_r != 4'd0) status_nxt = ST_REFUSED;
              else begin
                held_nxt      = data_byte;
                held_left_nxt = 4'd8;
                status_nxt    = ST_ACCEPT;
              end
            end else begin
              status_nxt = (cnt_r != '0) ? ST_PIXEL : ST_NEED;
            end
          end
        end
        S_BIT: begin
          held_nxt      = held_r >> 1;
          held_left_nxt = held_left_r - 4'd1;
          if (code_done) begin
            code_nxt     = {1'b0, accum_new};
            accum_nxt    = '0;
            acc_bits_nxt = '0;
          end else begin
            accum_nxt    = accum_new;
            acc_bits_nxt = acc_bits_r + 4'd1;
            status_nxt   = ST_NEED;
          end
        end
        S_DEC: begin
          walk_nxt   = code_r;
          status_nxt = ST_NEED;
          if (is_clear) begin
            next_free_nxt = clear_c + CODE_W'(2);
            width_nxt     = eff_r + 4'd1;
            prev_nxt      = NO_CODE;
          end else if (is_stop) begin
            stop_nxt = 1'b1;
          end else if (bad_code) begin
            failed_nxt = 1'b1;
            status_nxt = ST_ERROR;
          end else if (!do_add) begin
            prev_nxt = code_r;
          end
        end
        S_ADD: begin
          dwr.en     = 1'b1;
          dwr.addr   = next_free_r[DICT_BITS-1:0];
          dwr.prefix = prev_r;
          dwr.suffix = (code_r == next_free_r) ? prev_first : code_first;
          dwr.first  = prev_first;
          next_free_nxt = nf_inc;
          if (width_r < 4'(MAX_CODE_BITS) && nf_inc == (CODE_W'(1) << width_r))
            width_nxt = width_r + 4'd1;
          prev_nxt = code_r;
          walk_nxt = code_r;
        end
        S_PREP: begin
          cnt_nxt = '0;
        end
        S_WALK: begin
          stk_we   = 1'b1;
          cnt_nxt  = cnt_inc;
          walk_nxt = walk_prefix;
        end
        S_POP_RD: begin
          stk_re     = 1'b1;
          cnt_nxt    = cnt_dec;
          status_nxt = ST_PIXEL;
        end
        S_EMIT: ;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      eff_r       <= MIN_SIZE_RESET;
      cnt_r       <= '0;
      next_free_r <= (CODE_W'(1) << MIN_SIZE_RESET) + CODE_W'(2);
      width_r     <= MIN_SIZE_RESET + 4'd1;
      prev_r      <= NO_CODE;
      accum_r     <= '0;
      acc_bits_r  <= '0;
      held_r      <= '0;
      held_left_r <= '0;
      failed_r    <= 1'b0;
      stop_r      <= 1'b0;
      walk_r      <= NO_CODE;
      status_r    <= ST_ACCEPT;
    end else begin
      state_r     <= state_nxt;
      eff_r       <= eff_nxt;
      cnt_r       <= cnt_nxt;
      next_free_r <= next_free_nxt;
      width_r     <= width_nxt;
      prev_r      <= prev_nxt;
      accum_r     <= accum_nxt;
      acc_bits_r  <= acc_bits_nxt;
      held_r      <= held_nxt;
      held_left_r <= held_left_nxt;
      failed_r    <= failed_nxt;
      stop_r      <= stop_nxt;
      walk_r      <= walk_nxt;
      status_r    <= status_nxt;
    end
  end

  always_ff @(posedge clk) begin
    code_r <= code_nxt;
  end

  // outputs
  always_comb begin
    idle       = (state_r == S_IDLE);
    res_valid  = (state_r == S_EMIT);
    res_status = status_r;
    res_pixel  = (status_r == ST_PIXEL) ? stack_q : 8'd0;
    stop_flag  = stop_r;
  end

endmodule
`default_nettype wire

/* tb/testbench.sv */
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for gif_lzw_decoder. Well-formed LZW code streams are
// built here and packed LSB first into bytes. Push and pull commands are then
// issued as the decoder state allows, with some noise and broken streams
// mixed in. A scoreboard class predicts each result transaction and checks
// it field by field. Both channels idle in random bursts. The run sweeps the
// minimum code size and includes one longer stream without clear codes that
// grows the code width several times.
// ---------------------------------------------------------------------------
module testbench
  import gifl_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [2:0] status;
    logic [7:0] pixel;
    logic       stop;
  } lzw_result_t;

  // Decoder predictor plus the queue of pending results.
  class lzw_scoreboard;
    logic [12:0]  prefix_mem [DICT_SIZE];
    logic [7:0]   suffix_mem [DICT_SIZE];
    logic [7:0]   first_mem  [DICT_SIZE];
    logic [7:0]   pix_stack  [DICT_SIZE];
    int unsigned  stack_count, next_free, width, prev_code;
    int unsigned  accum, accum_bits, held, held_left;
    bit           failed, stop_flag;
    logic [3:0]   min_size;
    lzw_result_t  pending_q[$];
    int unsigned  errors, checked;

    function int unsigned eff_min();
      if (min_size < 2) return 2;
      if (min_size > 8) return 8;
      return min_size;
    endfunction

    function void reset_dict();
      int unsigned clr;
      clr = 1 << eff_min();
      for (int i = 0; i < clr; i++) begin
        prefix_mem[i] = NO_CODE;
        suffix_mem[i] = i[7:0];
        first_mem[i]  = i[7:0];
      end
      next_free = clr + 2;
      width     = eff_min() + 1;
      prev_code = NO_CODE;
    endfunction

    function void restart();
      for (int i = 0; i < DICT_SIZE; i++) begin
        prefix_mem[i] = '0;
        suffix_mem[i] = '0;
        first_mem[i]  = '0;
        pix_stack[i]  = '0;
      end
      reset_dict();
      stack_count = 0;
      accum = 0;
      accum_bits = 0;
      held = 0;
      held_left = 0;
      failed = 0;
      stop_flag = 0;
    endfunction

    function void set_min_size(logic [3:0] v);
      min_size = v;
      restart();
    endfunction

    function void decode_code(int unsigned code);
      int unsigned clr, walk, n;
      logic [7:0] fb;
      clr = 1 << eff_min();
      if (code == clr) begin
        reset_dict();
        return;
      end
      if (code == clr + 1) begin
        stop_flag = 1;
        return;
      end
      if (prev_code == NO_CODE) begin
        if (code >= clr) begin
          failed = 1;
          return;
        end
      end else if (next_free < DICT_SIZE) begin
        if (code > next_free) begin
          failed = 1;
          return;
        end
        // KwKwK case takes the first byte of the previous string
        fb = (code == next_free) ? first_mem[prev_code & 12'hFFF] : first_mem[code & 12'hFFF];
        prefix_mem[next_free] = prev_code[12:0];
        suffix_mem[next_free] = fb;
        first_mem[next_free]  = first_mem[prev_code & 12'hFFF];
        next_free++;
        if (width < 12 && next_free == (1 << width)) width++;
      end
      prev_code = code;
      walk = code;
      n = 0;
      while (walk != NO_CODE && n < DICT_SIZE) begin
        pix_stack[n] = suffix_mem[walk & 12'hFFF];
        n++;
        walk = prefix_mem[walk & 12'hFFF];
      end
      stack_count = n;
    endfunction

    // accepted input transaction: predict its result
    function void note_input(cmd_t cmd, logic [7:0] data);
      lzw_result_t r;
      r.status = ST_REFUSED;
      r.pixel  = '0;
      if (cmd == CMD_RESTART) begin
        restart();
        r.status = ST_ACCEPT;
      end else if (cmd == CMD_NONE) begin
        r.status = ST_REFUSED;
      end else if (failed) begin
        r.status = ST_ERROR;
      end else if (cmd == CMD_PUSH) begin
        if (held_left != 0) r.status = ST_REFUSED;
        else begin
          held = data;
          held_left = 8;
          r.status = ST_ACCEPT;
        end
      end else begin
        r.status = ST_NEED;
        while (stack_count == 0 && held_left != 0 && !failed) begin
          accum |= (held & 1) << accum_bits;
          held >>= 1;
          held_left--;
          accum_bits++;
          if (accum_bits >= width) begin
            int unsigned code;
            code = accum & 12'hFFF;
            accum = 0;
            accum_bits = 0;
            decode_code(code);
          end
        end
        if (failed) r.status = ST_ERROR;
        else if (stack_count != 0) begin
          stack_count--;
          r.pixel = pix_stack[stack_count];
          r.status = ST_PIXEL;
        end
      end
      r.stop = stop_flag;
      pending_q.push_back(r);
    endfunction

    function void check_result(logic [2:0] status, logic [7:0] pixel, logic stop);
      lzw_result_t e;
      if (pending_q.size() == 0) begin
        $error("result with nothing expected: status %0d pixel %0d", status, pixel);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      checked++;
      if (status !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, status);
        errors++;
      end
      if (pixel !== e.pixel) begin
        $error("pixel: expected %0d, got %0d", e.pixel, pixel);
        errors++;
      end
      if (stop !== e.stop) begin
        $error("stop_seen: expected %0d, got %0d", e.stop, stop);
        errors++;
      end
    endfunction
  endclass

  logic       clk, rst_n;
  logic       in_tvalid, in_tready;
  logic [7:0] in_tdata;
  logic [1:0] in_tuser;          // [1:0] command
  logic       out_tvalid, out_tready;
  logic [7:0] out_tdata;         // [7:0] pixel
  logic [3:0] out_tuser;         // [2:0] status, [3] stop_seen
  logic       cfg_tvalid, cfg_tready;
  logic [7:0] cfg_tdata;         // [3:0] min_code_size

  lzw_scoreboard sb;
  bit            quiet;          // no idling in the closing phase
  bit            hold_req;       // asks the receiver for one long hold-off
  logic [7:0]    byte_q[$];      // packed code stream awaiting push
  longint unsigned bit_buf;
  int unsigned   bit_cnt, n_streams, n_cfg;

  gif_lzw_decoder u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_tvalid(cfg_tvalid),
    .cfg_tready(cfg_tready),
    .cfg_tdata (cfg_tdata)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Generous ceiling: a slow correct run is well under a tenth of this
  initial begin
    #10ms;
    $display("testbench NOT OK");
    $finish;
  end

  // Result checker: sampled values are pre-edge, so ordering is safe
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(out_tuser[2:0], out_tdata, out_tuser[3]);
  end

  // Receiver back-pressure: random bursts plus one long hold-off
  initial begin
    out_tready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_req = 1'b0;
        out_tready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // One input transaction. Valid is left high after the handshake: the next
  // call, in the same time step, either lowers it or offers the next item.
  task automatic send_item(cmd_t cmd, logic [7:0] data);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= data;
    do @(posedge clk); while (!in_tready);
    sb.note_input(cmd, data);
  endtask

  task automatic write_min_size(logic [3:0] v);
    in_tvalid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    cfg_tvalid <= 1'b1;
    cfg_tdata  <= {4'($urandom_range(0, 15)), v};
    do @(posedge clk); while (!cfg_tready);
    cfg_tvalid <= 1'b0;
    sb.set_min_size(v);
    n_cfg++;
  endtask

  // LSB-first packer
  function automatic void emit_code(int unsigned code, int unsigned w);
    bit_buf |= longint'(code) << bit_cnt;
    bit_cnt += w;
    while (bit_cnt >= 8) begin
      byte_q.push_back(bit_buf[7:0]);
      bit_buf >>= 8;
      bit_cnt -= 8;
    end
  endfunction

  // Builds a legal code stream by tracking the encoder's view of the
  // dictionary; optionally ends in a code above the next free entry.
  function automatic void build_stream(int n_codes, bit end_bad, int root_pct,
                                       bit allow_clear);
    int unsigned m, clr, nf, w, code, r;
    bit first;
    m = sb.eff_min();
    clr = 1 << m;
    nf = clr + 2;
    w = m + 1;
    first = 1;
    bit_buf = 0;
    bit_cnt = 0;
    emit_code(clr, w);
    for (int i = 0; i < n_codes; i++) begin
      r = $urandom_range(0, 99);
      if (end_bad && i == n_codes - 1 && !first && nf + 1 < (1 << w)) begin
        emit_code($urandom_range(nf + 1, (1 << w) - 1), w);
        break;
      end
      if (first) begin
        emit_code($urandom_range(0, clr - 1), w);
        first = 0;
      end else if (allow_clear && r < 3) begin
        emit_code(clr, w);
        nf = clr + 2;
        w = m + 1;
        first = 1;
      end else if (r < 5) begin
        emit_code(clr + 1, w);
      end else begin
        if (r < root_pct) code = $urandom_range(0, clr - 1);
        else code = $urandom_range(clr + 2, (nf > 4095) ? 4095 : nf);
        emit_code(code, w);
        if (nf < DICT_SIZE) begin
          nf++;
          if (w < 12 && nf == (1 << w)) w++;
        end
      end
    end
    if ($urandom_range(0, 1)) emit_code(clr + 1, w);
    if (bit_cnt > 0) begin
      byte_q.push_back(bit_buf[7:0]);
      bit_cnt = 0;
    end
  endfunction

  // Restart, then push and pull until the stream is drained
  task automatic play_stream();
    n_streams++;
    send_item(CMD_RESTART, 8'($urandom));
    forever begin
      if (sb.failed) begin
        if (byte_q.size() == 0) break;
        send_item(CMD_PUSH, byte_q.pop_front());
      end else if (byte_q.size() == 0 && sb.stack_count == 0 && sb.held_left == 0) begin
        break;
      end else if (!quiet && $urandom_range(0, 24) == 0) begin
        // noise that must not disturb the stream
        if (sb.held_left != 0 && $urandom_range(0, 1)) send_item(CMD_PUSH, 8'($urandom));
        else send_item(CMD_NONE, 8'($urandom));
      end else if (sb.stack_count == 0 && sb.held_left == 0) begin
        send_item(CMD_PUSH, byte_q.pop_front());
      end else begin
        send_item(CMD_PULL, 8'($urandom));
      end
    end
  endtask

  initial begin
    logic [3:0] sizes[8];
    sizes = '{4'd2, 4'd15, 4'd0, 4'd5, 4'd8, 4'd1, 4'd12, 4'd3};
    sb = new();
    sb.set_min_size(MIN_SIZE_RESET);
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = CMD_NONE;
    cfg_tvalid = 1'b0;
    cfg_tdata  = '0;
    quiet      = 1'b0;
    hold_req   = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: unknown command, pull with no data
    send_item(CMD_NONE, 8'hFF);
    send_item(CMD_PULL, 8'h00);
    // extreme pixels, then stop code at width 9
    bit_buf = 0;
    bit_cnt = 0;
    emit_code(256, 9);
    emit_code(255, 9);
    emit_code(0, 9);
    emit_code(257, 9);
    byte_q.push_back(bit_buf[7:0]);
    play_stream();
    // partial code, push while a byte is held, non-root first code
    send_item(CMD_RESTART, 8'h00);
    send_item(CMD_PUSH, 8'h02);
    send_item(CMD_PUSH, 8'hFF);
    send_item(CMD_PULL, 8'h00);
    send_item(CMD_PUSH, 8'h01);
    send_item(CMD_PULL, 8'h00);
    // failed decoder refuses work until restart
    send_item(CMD_PUSH, 8'hAA);
    send_item(CMD_PULL, 8'h55);
    send_item(CMD_NONE, 8'h00);
    send_item(CMD_RESTART, 8'h00);
    send_item(CMD_PULL, 8'h00);

    // Random phases across the code size range
    foreach (sizes[i]) begin
      write_min_size(sizes[i]);
      for (int s = 0; s < 3; s++) begin
        if (i == 1 && s == 1) hold_req = 1'b1;   // fill the block up once
        build_stream($urandom_range(5, 30), s == 2, 60, 1'b1);
        play_stream();
      end
    end

    // Longer stream at the smallest size, no clears: width grows from 3 to 7
    write_min_size(4'd2);
    build_stream(120, 1'b0, 95, 1'b0);
    play_stream();

    // Closing phase without idling
    write_min_size(4'd8);
    quiet = 1'b1;
    for (int s = 0; s < 3; s++) begin
      build_stream($urandom_range(5, 30), 1'b0, 60, 1'b1);
      play_stream();
    end

    in_tvalid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Checked %0d results over %0d code streams and %0d code size writes,",
             sb.checked, n_streams, n_cfg);
    $display("including code width growth, error recovery and a long output stall.");
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
